// File: src/mbe_pkg.sv
// shared types, constants and helpers of the mandelbrot escape-time core
package mbe_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned STEP_W      = 31;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned PIXEL_W     = 12;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned WIDE_W      = 66;

  localparam int unsigned DEFAULT_INDEX_BITS    = 12;
  localparam int unsigned DEFAULT_FRACTION_BITS = 28;

  // reset values: left -2.5, bottom -1.0 in q4.28
  localparam logic signed [WORD_W-1:0] RESET_LEFT_EDGE   = -32'sd671088640;
  localparam logic signed [WORD_W-1:0] RESET_BOTTOM_EDGE = -32'sd268435456;
  localparam logic [STEP_W-1:0]        RESET_COLUMN_STEP = 31'd918401;
  localparam logic [STEP_W-1:0]        RESET_ROW_STEP    = 31'd524801;
  localparam logic [COUNT_W-1:0]       RESET_ITER_LIMIT  = 16'd100;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEFT_EDGE       = 3'd0,
    REG_BOTTOM_EDGE     = 3'd1,
    REG_COLUMN_STEP     = 3'd2,
    REG_ROW_STEP        = 3'd3,
    REG_ITERATION_LIMIT = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic signed [WORD_W-1:0] left_edge;
    logic signed [WORD_W-1:0] bottom_edge;
    logic [STEP_W-1:0]        column_step;
    logic [STEP_W-1:0]        row_step;
    logic [COUNT_W-1:0]       iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic load;   // capture pixel indexes
    logic map;    // register index * step products
    logic coord;  // form c, clear z and count
    logic mul;    // register squares and cross product
    logic step;   // update z, bump count
    logic emit;   // move count into the output register
  } cmd_t;

  typedef struct packed {
    logic at_limit;
    logic escaped;
  } status_t;

  // clamp a wide signed value to the 32-bit word range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if ((&v[WIDE_W-1:WORD_W-1]) || !(|v[WIDE_W-1:WORD_W-1])) begin
      r = v[WORD_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: src/mbe_cfg_regs.sv
// configuration register file of the mandelbrot escape-time core
module mbe_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [mbe_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [mbe_pkg::WORD_W-1:0]        cfg_data_i,
  output mbe_pkg::cfg_t                     cfg_o
);

  mbe_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (mbe_pkg::cfg_index_e'(cfg_index_i))
        mbe_pkg::REG_LEFT_EDGE:       cfg_d.left_edge       = cfg_data_i;
        mbe_pkg::REG_BOTTOM_EDGE:     cfg_d.bottom_edge     = cfg_data_i;
        mbe_pkg::REG_COLUMN_STEP:     cfg_d.column_step     = cfg_data_i[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_ROW_STEP:        cfg_d.row_step        = cfg_data_i[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_ITERATION_LIMIT: cfg_d.iteration_limit = cfg_data_i[mbe_pkg::COUNT_W-1:0];
        default:                      cfg_d = cfg_q;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_edge       <= mbe_pkg::RESET_LEFT_EDGE;
      cfg_q.bottom_edge     <= mbe_pkg::RESET_BOTTOM_EDGE;
      cfg_q.column_step     <= mbe_pkg::RESET_COLUMN_STEP;
      cfg_q.row_step        <= mbe_pkg::RESET_ROW_STEP;
      cfg_q.iteration_limit <= mbe_pkg::RESET_ITER_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/mbe_ctrl.sv
// sequencing state machine of the mandelbrot escape-time core
module mbe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  mbe_pkg::status_t  status_i,
  output mbe_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_COORD,
    S_MUL,
    S_ADD,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MAP;
        end
      end
      S_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = S_COORD;
      end
      S_COORD: begin
        cmd_o.coord = 1'b1;
        state_d     = S_MUL;
      end
      S_MUL: begin
        if (status_i.at_limit) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = S_ADD;
        end
      end
      S_ADD: begin
        if (status_i.escaped) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: src/mbe_datapath.sv
// coordinate mapping and z = z*z + c iteration datapath
module mbe_datapath #(
  parameter int unsigned INDEX_BITS    = mbe_pkg::DEFAULT_INDEX_BITS,
  parameter int unsigned FRACTION_BITS = mbe_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic                          clk_i,
  input  mbe_pkg::cfg_t                 cfg_i,
  input  mbe_pkg::cmd_t                 cmd_i,
  input  logic [mbe_pkg::PIXEL_W-1:0]   pixel_column_i,
  input  logic [mbe_pkg::PIXEL_W-1:0]   pixel_row_i,
  output mbe_pkg::status_t              status_o,
  output logic [mbe_pkg::COUNT_W-1:0]   escape_count_o
);

  localparam int unsigned IDX_W  = (INDEX_BITS < mbe_pkg::PIXEL_W) ? INDEX_BITS
                                                                   : mbe_pkg::PIXEL_W;
  localparam int unsigned MAP_W  = IDX_W + mbe_pkg::STEP_W;
  localparam int unsigned W      = mbe_pkg::WORD_W;
  localparam int unsigned WW     = mbe_pkg::WIDE_W;
  localparam int unsigned CW     = mbe_pkg::COUNT_W;
  localparam int unsigned PROD_W = 2 * W;
  localparam logic [PROD_W-1:0] BOUND = PROD_W'(4) << FRACTION_BITS;

  logic [IDX_W-1:0]          col_q, row_q;
  logic [MAP_W-1:0]          map_x_q, map_y_q;
  logic signed [W-1:0]       cx_q, cy_q, x_q, y_q;
  logic signed [PROD_W-1:0]  xx_q, yy_q, xy_q;
  logic [mbe_pkg::COUNT_W-1:0] count_q, escape_count_q;

  logic signed [WW-1:0]      coord_x, coord_y, nx, ny;
  logic signed [PROD_W-1:0]  xx_d, yy_d, xy_d;
  logic [PROD_W-1:0]         mag;

  // c = edge + index * step
  assign coord_x = $signed({{(WW-W){cfg_i.left_edge[W-1]}}, cfg_i.left_edge})
                 + $signed({{(WW-MAP_W){1'b0}}, map_x_q});
  assign coord_y = $signed({{(WW-W){cfg_i.bottom_edge[W-1]}}, cfg_i.bottom_edge})
                 + $signed({{(WW-MAP_W){1'b0}}, map_y_q});

  assign xx_d = PROD_W'(x_q) * PROD_W'(x_q);
  assign yy_d = PROD_W'(y_q) * PROD_W'(y_q);
  assign xy_d = PROD_W'(x_q) * PROD_W'(y_q);

  // exact escape test on the registered squares
  assign mag = $unsigned(xx_q) + $unsigned(yy_q);

  // floor shifts of the products, then add c
  assign nx = WW'(xx_q >>> FRACTION_BITS) - WW'(yy_q >>> FRACTION_BITS) + WW'(cx_q);
  assign ny = WW'(xy_q >>> (FRACTION_BITS - 1)) + WW'(cy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q <= pixel_column_i[IDX_W-1:0];
      row_q <= pixel_row_i[IDX_W-1:0];
    end
    if (cmd_i.map) begin
      map_x_q <= MAP_W'(col_q) * MAP_W'(cfg_i.column_step);
      map_y_q <= MAP_W'(row_q) * MAP_W'(cfg_i.row_step);
    end
    if (cmd_i.coord) begin
      cx_q    <= mbe_pkg::sat_word(coord_x);
      cy_q    <= mbe_pkg::sat_word(coord_y);
      x_q     <= '0;
      y_q     <= '0;
      count_q <= '0;
    end
    if (cmd_i.mul) begin
      xx_q <= xx_d;
      yy_q <= yy_d;
      xy_q <= xy_d;
    end
    if (cmd_i.step) begin
      x_q     <= mbe_pkg::sat_word(nx);
      y_q     <= mbe_pkg::sat_word(ny);
      count_q <= count_q + CW'(1);
    end
    if (cmd_i.emit) begin
      escape_count_q <= count_q;
    end
  end

  assign status_o.at_limit = (count_q >= cfg_i.iteration_limit);
  assign status_o.escaped  = ((mag >> FRACTION_BITS) >= BOUND);
  assign escape_count_o    = escape_count_q;

endmodule

// File: src/mandelbrot_escape_iteration_core.sv
// top level of the mandelbrot escape-time core
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ------------------------------------
//  in        input      in_valid_i/in_stall_o pixel_column_i, pixel_row_i
//  out       output     out_valid_o/out_stall_i escape_count_o
//  cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  a pixel runs through load, map and coordinate steps, then a loop per iteration
//    (squares and cross product registered, then escape test and z update) through
//    three 32x32 multipliers until the count reaches the limit or z escapes
//  one pixel is in flight at a time; in_stall_o is high from the accepted beat
//    until its count has moved into the output register, so the next beat is taken
//    only after that hand-off
//  the output register holds a finished beat, so the next pixel is taken while
//    out_stall_i keeps the previous count waiting
//  rst_ni clears control state and loads the default view of the plane
module mandelbrot_escape_iteration_core #(
  parameter int unsigned INDEX_BITS    = mbe_pkg::DEFAULT_INDEX_BITS,
  parameter int unsigned FRACTION_BITS = mbe_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pixel beats
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mbe_pkg::PIXEL_W-1:0]       pixel_column_i,
  input  logic [mbe_pkg::PIXEL_W-1:0]       pixel_row_i,
  // count beats
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mbe_pkg::COUNT_W-1:0]       escape_count_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mbe_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [mbe_pkg::WORD_W-1:0]        cfg_data_i
);

  mbe_pkg::cfg_t    cfg;
  mbe_pkg::cmd_t    cmd;
  mbe_pkg::status_t status;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  mbe_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequencer: setup, multiply / update loop, hand-off to the output register
  mbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // fixed-point mapping, iteration and output count register
  mbe_datapath #(
    .INDEX_BITS    (INDEX_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .pixel_column_i (pixel_column_i),
    .pixel_row_i    (pixel_row_i),
    .status_o       (status),
    .escape_count_o (escape_count_o)
  );

endmodule

// File: tb/tb_mandelbrot_escape_iteration_core.sv
// testbench for the mandelbrot escape-time core: pixel beats in, escape counts checked
`timescale 1ns / 1ps

module tb_mandelbrot_escape_iteration_core;

  // fraction bits of the q4.28 words, as the core is built by default
  localparam int FRAC = mbe_pkg::DEFAULT_FRACTION_BITS;
  localparam int unsigned DATA_W = mbe_pkg::WORD_W;
  localparam int unsigned PIX_W = mbe_pkg::PIXEL_W;
  localparam longint WORD_TOP = 64'sd2147483647;
  localparam longint WORD_BOTTOM = -64'sd2147483648;
  // register index the core has no register behind
  localparam logic [mbe_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  // receiver hold-off, long enough for the core to fill and stall pixel beats
  localparam int HOLD_CYCLES = 600;
  localparam int PHASES = 14;
  localparam int PIXELS_PER_PHASE = 125;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [mbe_pkg::PIXEL_W-1:0] pixel_column_i = '0;
  logic [mbe_pkg::PIXEL_W-1:0] pixel_row_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [mbe_pkg::COUNT_W-1:0] escape_count_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [mbe_pkg::CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [mbe_pkg::WORD_W-1:0] cfg_data_i = '0;

  // idling of both sides, set per phase by the stimulus
  idle_e idle_mode = IDLE_NONE;
  // each bump asks the receiver for one long hold-off
  int hold_order = 0;
  int hold_seen = 0;
  int hold_left = 0;
  // size of the current image, bounds the in-image pixel indexes
  int unsigned view_cols = 4096;
  int unsigned view_rows = 4096;

  // tracks the view registers and the escape counts still owed by the core
  class escape_tracker;
    logic signed [mbe_pkg::WORD_W-1:0] left;
    logic signed [mbe_pkg::WORD_W-1:0] bottom;
    logic [mbe_pkg::STEP_W-1:0] cstep;
    logic [mbe_pkg::STEP_W-1:0] rstep;
    logic [mbe_pkg::COUNT_W-1:0] limit;
    logic [mbe_pkg::COUNT_W-1:0] counts_due[$];
    int errors;

    function new();
      left = mbe_pkg::RESET_LEFT_EDGE;
      bottom = mbe_pkg::RESET_BOTTOM_EDGE;
      cstep = mbe_pkg::RESET_COLUMN_STEP;
      rstep = mbe_pkg::RESET_ROW_STEP;
      limit = mbe_pkg::RESET_ITER_LIMIT;
      errors = 0;
    endfunction

    function void set_reg(logic [mbe_pkg::CFG_INDEX_W-1:0] idx,
                          logic [mbe_pkg::WORD_W-1:0] data);
      case (idx)
        mbe_pkg::REG_LEFT_EDGE: left = data;
        mbe_pkg::REG_BOTTOM_EDGE: bottom = data;
        mbe_pkg::REG_COLUMN_STEP: cstep = data[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_ROW_STEP: rstep = data[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_ITERATION_LIMIT: limit = data[mbe_pkg::COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_word(longint v);
      if (v > WORD_TOP) return WORD_TOP;
      if (v < WORD_BOTTOM) return WORD_BOTTOM;
      return v;
    endfunction

    function logic [mbe_pkg::COUNT_W-1:0] escape_count_of(logic [mbe_pkg::PIXEL_W-1:0] col,
                                                          logic [mbe_pkg::PIXEL_W-1:0] row);
      longint cx, cy, x, y, xx, yy, nx, ny;
      longint unsigned mag;
      int unsigned n;
      cx = clamp_word(longint'(left) + longint'(col) * longint'(cstep));
      cy = clamp_word(longint'(bottom) + longint'(row) * longint'(rstep));
      x = 0;
      y = 0;
      n = 0;
      while (n < limit) begin
        xx = x * x;
        yy = y * y;
        mag = $unsigned(xx) + $unsigned(yy);
        // exact |z|^2 >= 4 test on the full products
        if ((mag >> FRAC) >= (64'd4 << FRAC)) break;
        nx = (xx >>> FRAC) - (yy >>> FRAC) + cx;
        ny = ((x * y) >>> (FRAC - 1)) + cy;
        x = clamp_word(nx);
        y = clamp_word(ny);
        n++;
      end
      return n[mbe_pkg::COUNT_W-1:0];
    endfunction

    function void note_pixel(logic [mbe_pkg::PIXEL_W-1:0] col,
                             logic [mbe_pkg::PIXEL_W-1:0] row);
      counts_due.push_back(escape_count_of(col, row));
    endfunction

    function int pending();
      return counts_due.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_count(logic [mbe_pkg::COUNT_W-1:0] got);
      logic [mbe_pkg::COUNT_W-1:0] want;
      if (counts_due.size() == 0) begin
        report_mismatch($sformatf("escape count %0d with no pixel pending", got));
      end else begin
        want = counts_due.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("escape count %0d, predicted %0d", got, want));
        end
      end
    endtask
  endclass

  escape_tracker book = new();

  mandelbrot_escape_iteration_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .pixel_column_i(pixel_column_i),
    .pixel_row_i(pixel_row_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .escape_count_o(escape_count_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver: random stalls per idle mode, or a counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_order != hold_seen) begin
      hold_seen = hold_order;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= $urandom_range(0, 99) <
                     ((idle_mode == IDLE_RECV) ? 53 : (idle_mode == IDLE_BOTH) ? 37 : 0);
    end
  end

  // count beats are checked at the edge that takes them
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      book.check_count(escape_count_o);
    end
  end

  // one pixel beat; entered and left at a falling edge, valid stays up on exit
  task automatic send_pixel(input logic [mbe_pkg::PIXEL_W-1:0] col,
                            input logic [mbe_pkg::PIXEL_W-1:0] row);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 53 : (idle_mode == IDLE_BOTH) ? 37 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_column_i <= col;
    pixel_row_i <= row;
    do @(posedge clk_i); while (in_stall_o);
    book.note_pixel(col, row);
    @(negedge clk_i);
  endtask

  // stop offering pixels until every owed count has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (book.pending() != 0);
  endtask

  // one register write beat; valid is left high for a following write
  task automatic write_reg(input logic [mbe_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mbe_pkg::WORD_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    book.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  // full view of the plane plus the iteration limit, only while idle
  task automatic set_view(input logic [mbe_pkg::WORD_W-1:0] left_v,
                          input logic [mbe_pkg::WORD_W-1:0] bottom_v,
                          input logic [mbe_pkg::WORD_W-1:0] cstep_v,
                          input logic [mbe_pkg::WORD_W-1:0] rstep_v,
                          input logic [mbe_pkg::WORD_W-1:0] lim_v);
    write_reg(mbe_pkg::REG_LEFT_EDGE, left_v);
    write_reg(mbe_pkg::REG_BOTTOM_EDGE, bottom_v);
    write_reg(mbe_pkg::REG_COLUMN_STEP, cstep_v);
    write_reg(mbe_pkg::REG_ROW_STEP, rstep_v);
    write_reg(mbe_pkg::REG_ITERATION_LIMIT, lim_v);
    cfg_valid_i <= 1'b0;
  endtask

  // random view: a window around the set, steps as span over pixel count minus one
  task automatic random_view();
    logic [mbe_pkg::WORD_W-1:0] junk;
    int left_v, bottom_v;
    int unsigned span_x, span_y, cstep_v, rstep_v;
    junk = $urandom;
    view_cols = $urandom_range(2, 4096);
    view_rows = $urandom_range(2, 4096);
    span_x = $urandom_range(32'd1 << 26, 32'd3 << 28);
    span_y = $urandom_range(32'd1 << 26, 32'd5 << 27);
    cstep_v = span_x / (view_cols - 1);
    rstep_v = span_y / (view_rows - 1);
    left_v = -671088640 + int'($urandom_range(0, 402653184));
    bottom_v = -335544320 + int'($urandom_range(0, 335544320));
    // spare data bits above the step and limit registers are filled with noise
    set_view(left_v, bottom_v, {junk[31], cstep_v[30:0]}, {junk[30], rstep_v[30:0]},
             {junk[31:16], 16'($urandom_range(1, 128))});
  endtask

  // registers with every bit random, short limit to keep pixels quick
  task automatic raw_view();
    logic [mbe_pkg::WORD_W-1:0] junk;
    junk = $urandom;
    view_cols = 4096;
    view_rows = 4096;
    set_view($urandom, $urandom, $urandom, $urandom, {junk[31:16], 16'($urandom_range(1, 64))});
  endtask

  initial begin
    int ph, k;
    logic [mbe_pkg::PIXEL_W-1:0] col, row;
    // reset held low from the start, released between edges
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // default view straight out of reset: corners, far columns saturate the real part
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd2048, 12'd1024);
    drain();

    // real part just below, at and just above 2: the exact escape boundary
    set_view(32'h1FFF_FFFF, 32'h0, 32'd1, 32'd0, DATA_W'(mbe_pkg::RESET_ITER_LIMIT));
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd2, 12'd0);
    send_pixel(12'd0, 12'd4095);
    drain();

    // extreme edges and steps, coordinates start at the word's ends and clamp high
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd50);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd0);
    drain();

    // largest limit: origin never escapes, c = 2 escapes at once
    set_view(32'h0, 32'h0, 32'h2000_0000, 32'd0, 32'h0000_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    drain();

    // limit of one, then a write to an index with no register, then limit zero
    set_view(mbe_pkg::RESET_LEFT_EDGE, mbe_pkg::RESET_BOTTOM_EDGE,
             DATA_W'(mbe_pkg::RESET_COLUMN_STEP), DATA_W'(mbe_pkg::RESET_ROW_STEP), 32'd1);
    send_pixel(12'd1000, 12'd500);
    drain();
    write_reg(REG_UNUSED, $urandom);
    set_view(mbe_pkg::RESET_LEFT_EDGE, mbe_pkg::RESET_BOTTOM_EDGE,
             DATA_W'(mbe_pkg::RESET_COLUMN_STEP), DATA_W'(mbe_pkg::RESET_ROW_STEP), 32'd0);
    send_pixel(12'd1000, 12'd500);
    send_pixel(12'd0, 12'd0);
    drain();

    // random phases, each with its own view and idle pattern
    for (ph = 0; ph < PHASES; ph++) begin
      idle_mode = idle_e'(ph % 4);
      if ($urandom_range(0, 3) == 0) begin
        raw_view();
      end else begin
        random_view();
      end
      for (k = 0; k < PIXELS_PER_PHASE; k++) begin
        // receiver holds off while pixels keep coming, so the core backs up
        if (ph == 2 && k == 20) hold_order++;
        // sender waits out every owed count mid-phase
        if (ph == 5 && k == 60) drain();
        if ($urandom_range(0, 9) == 0) begin
          col = PIX_W'($urandom);
          row = PIX_W'($urandom);
        end else begin
          col = PIX_W'($urandom_range(0, view_cols - 1));
          row = PIX_W'($urandom_range(0, view_rows - 1));
        end
        send_pixel(col, row);
      end
      drain();
    end

    // quiet tail catches any stray count
    repeat (300) @(negedge clk_i);
    if (book.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
